FILE: rtl/core/lodgs_pkg.sv
// Shared types, field widths and register codes for the LOD octree placement block.
package lodgs_pkg;

	// Field widths fixed by the point and result formats
	localparam int COORD_W    = 32;
	localparam int INDEX_W    = 32;
	localparam int OFF_W      = COORD_W - 1;
	localparam int SHIFT_W    = 5;
	localparam int LVL_OUT_W  = 2;
	localparam int NODE_OUT_W = 3;
	localparam int CELL_OUT_W = 12;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_DEEPEST_LEVEL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CUBE_SHIFT    = 3'd4;

	localparam logic [LVL_OUT_W-1:0] RST_DEEPEST_LEVEL = 2'd3;
	localparam logic [SHIFT_W-1:0]   RST_CUBE_SHIFT    = 5'd16;

	// Register file contents handed to the datapath
	typedef struct packed {
		logic [LVL_OUT_W-1:0]      deepest_level;
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] origin_z;
		logic [SHIFT_W-1:0]        cube_shift;
	} cfg_t;

	// First node number of a level in the flattened node list: sum of 8^k for k < lvl
	function automatic int lvl_base(input int lvl);
		int acc;
		acc = 0;
		for (int k = 0; k < 7; k++) begin
			if (k < lvl) begin
				acc = acc + (1 << (3 * k));
			end
		end
		return acc;
	endfunction

endpackage

FILE: rtl/core/lodgs_if.sv
// Channel interfaces: point input, placement result and configuration write.
interface lodgs_pt_if;
	import lodgs_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic signed [COORD_W-1:0] coord_z;
	logic [INDEX_W-1:0]        point_index;
	modport source(output valid, coord_x, coord_y, coord_z, point_index, input ready);
	modport sink(input valid, coord_x, coord_y, coord_z, point_index, output ready);
endinterface

interface lodgs_res_if;
	import lodgs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [INDEX_W-1:0]    point_index_out;
	logic [LVL_OUT_W-1:0]  level;
	logic [NODE_OUT_W-1:0] node_x;
	logic [NODE_OUT_W-1:0] node_y;
	logic [NODE_OUT_W-1:0] node_z;
	logic [CELL_OUT_W-1:0] cell_res;
	logic                  cell_recorded;
	modport source(output valid, point_index_out, level, node_x, node_y, node_z,
		cell_res, cell_recorded, input ready);
	modport sink(input valid, point_index_out, level, node_x, node_y, node_z,
		cell_res, cell_recorded, output ready);
endinterface

interface lodgs_cfg_if;
	import lodgs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/core/lod_octree_grid_sample_insert.sv
// Top level: level-of-detail octree placement of points by grid subsampling.
//
// Points enter on the pts channel (valid/ready), one word per point: x, y, z and an index.
// Each point is offset by the cube origin, clamped into the cube and then tried at levels
// 0, 1, ... in turn. Each level costs one read of the occupancy RAM and a test of the
// bit; the first clear bit is set by a write-back and the point is placed there. At the
// deepest configured level the point is placed without a RAM access.
// One point is in flight at a time; the next point can be taken in the cycle after the result
// of the last one is loaded.
// The result sits in an output register; a stalled receiver blocks only the next result,
// while the next point is still taken and worked on up to its result.
// After reset the occupancy RAM is cleared one row per cycle (4672 rows with the default
// parameters, one row per 64 occupancy bits); pts.ready stays low until that is done.
// Config writes on cfg are taken in any cycle and must only be made while no point is open.
module lod_octree_grid_sample_insert #(
	parameter int GRID_BITS   = 4,
	parameter int DEPTH_LIMIT = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	lodgs_cfg_if.sink   cfg,
	lodgs_pt_if.sink    pts,
	lodgs_res_if.source res
);
	import lodgs_pkg::*;

	localparam int CELL_BITS    = 3 * GRID_BITS;
	localparam int STORED_NODES = ((1 << (3 * DEPTH_LIMIT)) - 1) / 7;
	localparam int WORD_LOG     = (CELL_BITS < 6) ? CELL_BITS : 6;
	localparam int WORD_BITS    = 1 << WORD_LOG;
	localparam int ROWS         = STORED_NODES << (CELL_BITS - WORD_LOG);
	localparam int RAM_DEPTH    = (ROWS > 0) ? ROWS : 1;
	localparam int RAM_AW       = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
	localparam int NODE_W       = (STORED_NODES > 1) ? $clog2(STORED_NODES) : 1;
	localparam int BA_W         = NODE_W + CELL_BITS;
	localparam int NB           = (DEPTH_LIMIT > 0) ? DEPTH_LIMIT : 1;
	localparam int NIDX_W       = 3 * NB;
	localparam int LVL_W        = (DEPTH_LIMIT > 0) ? $clog2(DEPTH_LIMIT + 1) : 1;
	localparam int PAD          = DEPTH_LIMIT + GRID_BITS;
	localparam int AL_W         = OFF_W + PAD;
	localparam int CELL_EXT_W   = (CELL_BITS > CELL_OUT_W) ? CELL_BITS : CELL_OUT_W;
	localparam int NODE_EXT_W   = (NB > NODE_OUT_W) ? NB : NODE_OUT_W;
	localparam int LVL_EXT_W    = (LVL_W > LVL_OUT_W) ? LVL_W : LVL_OUT_W;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_ALIGN = 6'b000100,
		S_READ  = 6'b001000,
		S_CHECK = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	cfg_t   regs;
	state_t state_q;

	logic [RAM_AW-1:0]    clr_q;
	logic [LVL_W-1:0]     lvl_q;
	logic [INDEX_W-1:0]   idx_q;
	logic [RAM_AW-1:0]    row_q;
	logic [WORD_LOG-1:0]  bit_q;

	// pending result
	logic [LVL_OUT_W-1:0]  res_lvl_q;
	logic [NODE_OUT_W-1:0] res_nx_q, res_ny_q, res_nz_q;
	logic [CELL_OUT_W-1:0] res_cell_q;
	logic                  res_rec_q;

	// output register
	logic                  out_valid_q;
	logic [INDEX_W-1:0]    out_idx_q;
	logic [LVL_OUT_W-1:0]  out_lvl_q;
	logic [NODE_OUT_W-1:0] out_nx_q, out_ny_q, out_nz_q;
	logic [CELL_OUT_W-1:0] out_cell_q;
	logic                  out_rec_q;

	logic              pt_acc;
	logic [AL_W-1:0]   vx, vy, vz;
	logic [AL_W-1:0]   sx, sy, sz;
	logic [GRID_BITS-1:0] cx, cy, cz;
	logic [NB-1:0]     nx, ny, nz;
	logic [NIDX_W-1:0] node_idx;
	logic [NODE_W-1:0] node_sum;
	logic [BA_W-1:0]   bit_addr;
	logic [LVL_W-1:0]  last_lvl;
	logic              at_last;
	logic [CELL_EXT_W-1:0] cell_ext;
	logic [NODE_EXT_W-1:0] nx_ext, ny_ext, nz_ext;
	logic [LVL_EXT_W-1:0]  lvl_ext;
	logic              out_free;

	logic                 ram_we, ram_re;
	logic [RAM_AW-1:0]    ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
	logic                 rd_bit;

	lodgs_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	assign pts.ready = (state_q == S_IDLE);
	assign pt_acc    = pts.valid && pts.ready;

	lodgs_axis #(.PAD(PAD)) u_ax_x (
		.clk(clk), .ld_s1(pt_acc), .ld_s2(state_q == S_ALIGN),
		.coord(pts.coord_x), .origin(regs.origin_x), .cube_shift(regs.cube_shift),
		.aligned(vx)
	);
	lodgs_axis #(.PAD(PAD)) u_ax_y (
		.clk(clk), .ld_s1(pt_acc), .ld_s2(state_q == S_ALIGN),
		.coord(pts.coord_y), .origin(regs.origin_y), .cube_shift(regs.cube_shift),
		.aligned(vy)
	);
	lodgs_axis #(.PAD(PAD)) u_ax_z (
		.clk(clk), .ld_s1(pt_acc), .ld_s2(state_q == S_ALIGN),
		.coord(pts.coord_z), .origin(regs.origin_z), .cube_shift(regs.cube_shift),
		.aligned(vz)
	);

	// effective deepest level, saturated to the stored depth
	always_comb begin
		if (int'(regs.deepest_level) > DEPTH_LIMIT) begin
			last_lvl = LVL_W'(DEPTH_LIMIT);
		end else begin
			last_lvl = LVL_W'(regs.deepest_level);
		end
		at_last = (lvl_q >= last_lvl);
	end

	// node = top lvl bits, cell = next GRID_BITS bits of each aligned offset
	always_comb begin
		sx = vx << lvl_q;
		sy = vy << lvl_q;
		sz = vz << lvl_q;
		cx = sx[AL_W-1 -: GRID_BITS];
		cy = sy[AL_W-1 -: GRID_BITS];
		cz = sz[AL_W-1 -: GRID_BITS];
		nx = vx[AL_W-1 -: NB] >> (LVL_W'(NB) - lvl_q);
		ny = vy[AL_W-1 -: NB] >> (LVL_W'(NB) - lvl_q);
		nz = vz[AL_W-1 -: NB] >> (LVL_W'(NB) - lvl_q);
		node_idx = (NIDX_W'(nz) << (2 * lvl_q)) | (NIDX_W'(ny) << lvl_q) | NIDX_W'(nx);
		node_sum = NODE_W'(lvl_base(int'(lvl_q))) + NODE_W'(node_idx);
		bit_addr = {node_sum, cz, cy, cx};
		cell_ext = CELL_EXT_W'({cz, cy, cx});
		nx_ext   = NODE_EXT_W'(nx);
		ny_ext   = NODE_EXT_W'(ny);
		nz_ext   = NODE_EXT_W'(nz);
		lvl_ext  = LVL_EXT_W'(lvl_q);
	end

	// occupancy RAM: clearing sweep, per-level read, write-back of the set bit
	assign rd_bit   = ram_rdata[bit_q];
	assign ram_re   = (state_q == S_READ) && !at_last;
	assign ram_we   = (state_q == S_CLEAR) || ((state_q == S_CHECK) && !rd_bit);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : row_q;
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : (ram_rdata | (WORD_BITS'(1) << bit_q));

	lodgs_ram #(.WIDTH(WORD_BITS), .DEPTH(RAM_DEPTH)) u_occ (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (bit_addr[WORD_LOG +: RAM_AW]),
		.rdata (ram_rdata)
	);

	assign out_free = !out_valid_q || res.ready;

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			lvl_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (clr_q == RAM_AW'(RAM_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
					clr_q <= clr_q + 1'b1;
				end
				S_IDLE: begin
					if (pt_acc) begin
						state_q <= S_ALIGN;
					end
				end
				S_ALIGN: begin
					lvl_q   <= '0;
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= at_last ? S_DONE : S_CHECK;
				end
				S_CHECK: begin
					if (rd_bit) begin
						lvl_q   <= lvl_q + 1'b1;
						state_q <= S_READ;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (pt_acc) begin
			idx_q <= pts.point_index;
		end
		if (state_q == S_READ) begin
			row_q     <= bit_addr[WORD_LOG +: RAM_AW];
			bit_q     <= bit_addr[WORD_LOG-1:0];
			res_lvl_q <= lvl_ext[LVL_OUT_W-1:0];
			res_nx_q  <= nx_ext[NODE_OUT_W-1:0];
			res_ny_q  <= ny_ext[NODE_OUT_W-1:0];
			res_nz_q  <= nz_ext[NODE_OUT_W-1:0];
			res_cell_q <= at_last ? '0 : cell_ext[CELL_OUT_W-1:0];
			res_rec_q <= 1'b0;
		end
		if ((state_q == S_CHECK) && !rd_bit) begin
			res_rec_q <= 1'b1;
		end
		if ((state_q == S_DONE) && out_free) begin
			out_idx_q  <= idx_q;
			out_lvl_q  <= res_lvl_q;
			out_nx_q   <= res_nx_q;
			out_ny_q   <= res_ny_q;
			out_nz_q   <= res_nz_q;
			out_cell_q <= res_cell_q;
			out_rec_q  <= res_rec_q;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.point_index_out = out_idx_q;
	assign res.level           = out_lvl_q;
	assign res.node_x          = out_nx_q;
	assign res.node_y          = out_ny_q;
	assign res.node_z          = out_nz_q;
	assign res.cell_res        = out_cell_q;
	assign res.cell_recorded   = out_rec_q;

`ifndef SYNTHESIS
	// an accepted point always moves on to alignment
	a_accept_align: assert property (@(posedge clk) disable iff (!arst_n)
		pts.valid && pts.ready |=> state_q == S_ALIGN)
		else $error("accepted point did not enter alignment");

	// no occupancy lookups while the RAM is being cleared
	a_no_read_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !ram_re)
		else $error("occupancy read during clearing sweep");

	// the level walk never runs past the stored depth
	a_lvl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> int'(lvl_q) <= DEPTH_LIMIT)
		else $error("level counter beyond depth limit");

	// a write-back only follows a read that found the bit clear
	a_wb_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && state_q == S_CHECK |-> $past(ram_re))
		else $error("occupancy write-back without a preceding read");
`endif
endmodule

FILE: rtl/core/lodgs_ram.sv
// Generic simple dual-port RAM with registered read data.
module lodgs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4672
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/core/lodgs_cfg_regs.sv
// Configuration register file written through the config channel.
module lodgs_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	lodgs_cfg_if.sink    cfg,
	output lodgs_pkg::cfg_t regs
);
	import lodgs_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.deepest_level <= RST_DEEPEST_LEVEL;
			regs_q.origin_x      <= '0;
			regs_q.origin_y      <= '0;
			regs_q.origin_z      <= '0;
			regs_q.cube_shift    <= RST_CUBE_SHIFT;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_DEEPEST_LEVEL: regs_q.deepest_level <= cfg.data[LVL_OUT_W-1:0];
				CFG_ORIGIN_X:      regs_q.origin_x <= cfg.data;
				CFG_ORIGIN_Y:      regs_q.origin_y <= cfg.data;
				CFG_ORIGIN_Z:      regs_q.origin_z <= cfg.data;
				CFG_CUBE_SHIFT:    regs_q.cube_shift <= cfg.data[SHIFT_W-1:0];
				default: begin
				end
			endcase
		end
	end
endmodule

FILE: rtl/core/lodgs_axis.sv
// One coordinate axis: origin offset and clamp, then alignment of the cube's top bit to the MSB.
module lodgs_axis #(
	parameter int PAD = 7
) (
	input  logic                               clk,
	input  logic                               ld_s1,
	input  logic                               ld_s2,
	input  logic signed [lodgs_pkg::COORD_W-1:0] coord,
	input  logic signed [lodgs_pkg::COORD_W-1:0] origin,
	input  logic [lodgs_pkg::SHIFT_W-1:0]      cube_shift,
	output logic [lodgs_pkg::OFF_W+PAD-1:0]    aligned
);
	import lodgs_pkg::*;

	localparam int AL_W = OFF_W + PAD;

	logic signed [COORD_W:0] diff;
	logic [OFF_W-1:0]        top;
	logic                    over;
	logic [OFF_W-1:0]        off;
	logic [OFF_W-1:0]        off_s1;
	logic [AL_W-1:0]         aligned_s2;

	// offset from the cube corner, clamped to 0 .. 2^cube_shift - 1
	always_comb begin
		diff = {coord[COORD_W-1], coord} - {origin[COORD_W-1], origin};
		top  = ~({OFF_W{1'b1}} << cube_shift);
		over = diff[COORD_W-1] | (|(diff[OFF_W-1:0] & ~top));
		if (diff[COORD_W]) begin
			off = '0;
		end else if (over) begin
			off = top;
		end else begin
			off = diff[OFF_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			off_s1 <= off;
		end
		// cube bit 2^(cube_shift-1) lands on the MSB; zeros fill below unit resolution
		if (ld_s2) begin
			aligned_s2 <= {off_s1, {PAD{1'b0}}} << (SHIFT_W'(OFF_W) - cube_shift);
		end
	end

	assign aligned = aligned_s2;
endmodule

FILE: test/tb_lod_octree_grid_sample_insert.sv
// Testbench for the LOD octree placement block: directed and random points vs. a predictor.
module tb_lod_octree_grid_sample_insert;
	import lodgs_pkg::*;

	localparam int GRID_BITS   = 4;
	localparam int DEPTH_LIMIT = 3;
	localparam int CELLS       = 1 << (3 * GRID_BITS);
	localparam int OCC_BITS    = ((1 << (3 * DEPTH_LIMIT)) - 1) / 7 * CELLS;
	localparam int CLUSTERS    = 6;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_WORDS = 200;
	localparam int TAIL_WORDS  = 250;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_CUBE_SHIFT + 1'b1;

	// One expected placement result
	typedef struct packed {
		logic [INDEX_W-1:0]    index;
		logic [LVL_OUT_W-1:0]  level;
		logic [NODE_OUT_W-1:0] node_x;
		logic [NODE_OUT_W-1:0] node_y;
		logic [NODE_OUT_W-1:0] node_z;
		logic [CELL_OUT_W-1:0] cell_res;
		logic                  cell_recorded;
	} placement_t;

	logic clk;
	logic arst_n;

	lodgs_cfg_if cfg_ch();
	lodgs_pt_if  pt_ch();
	lodgs_res_if res_ch();

	lod_octree_grid_sample_insert #(
		.GRID_BITS(GRID_BITS),
		.DEPTH_LIMIT(DEPTH_LIMIT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.pts(pt_ch),
		.res(res_ch)
	);

	// Predictor state: register shadow and occupancy map
	cfg_t       shadow;
	bit         occ_seen [OCC_BITS];
	placement_t placed_q [$];
	longint     hot [3][CLUSTERS];
	int         err_count = 0;
	bit         idle_on;
	int         ready_hold = 0;

	always #5 clk = ~clk;

	// Offset into the cube, clamped to 0 .. 2^sh - 1
	function automatic longint clamp_offset(logic signed [COORD_W-1:0] raw,
			logic signed [COORD_W-1:0] org, int sh);
		longint d;
		longint top;
		d = longint'(raw) - longint'(org);
		top = (longint'(1) << sh) - 1;
		if (d < 0) d = 0;
		if (d > top) d = top;
		return d;
	endfunction

	// Right shift for sh >= 0, left shift when the cells are finer than one unit
	function automatic longint scale_off(longint d, int sh);
		if (sh >= 0) return d >> sh;
		return d << (-sh);
	endfunction

	// Place one point: first level with a clear occupancy bit, else the deepest level
	function automatic placement_t predict_placement(logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
			logic [INDEX_W-1:0] idx);
		placement_t r;
		longint     off [3];
		longint     nd [3];
		longint     cl [3];
		longint     nmask;
		longint     node;
		longint     cell_idx;
		longint     addr;
		int         last;
		int         ks;
		int         cs;
		off[0] = clamp_offset(x, shadow.origin_x, int'(shadow.cube_shift));
		off[1] = clamp_offset(y, shadow.origin_y, int'(shadow.cube_shift));
		off[2] = clamp_offset(z, shadow.origin_z, int'(shadow.cube_shift));
		last = (int'(shadow.deepest_level) < DEPTH_LIMIT) ? int'(shadow.deepest_level)
			: DEPTH_LIMIT;
		r = '0;
		r.index = idx;
		for (int l = 0; l <= DEPTH_LIMIT; l++) begin
			ks = int'(shadow.cube_shift) - l;
			cs = ks - GRID_BITS;
			nmask = (longint'(1) << l) - 1;
			for (int a = 0; a < 3; a++) nd[a] = scale_off(off[a], ks) & nmask;
			r.level  = LVL_OUT_W'(l);
			r.node_x = NODE_OUT_W'(nd[0]);
			r.node_y = NODE_OUT_W'(nd[1]);
			r.node_z = NODE_OUT_W'(nd[2]);
			if (l >= last) break;
			for (int a = 0; a < 3; a++) begin
				cl[a] = scale_off(off[a], cs) & ((longint'(1) << GRID_BITS) - 1);
			end
			node = (nd[2] << (2 * l)) | (nd[1] << l) | nd[0];
			cell_idx = (cl[2] << (2 * GRID_BITS)) | (cl[1] << GRID_BITS) | cl[0];
			addr = ((((longint'(1) << (3 * l)) - 1) / 7) + node) * CELLS + cell_idx;
			if (!occ_seen[addr]) begin
				occ_seen[addr] = 1'b1;
				r.cell_recorded = 1'b1;
				r.cell_res = CELL_OUT_W'(cell_idx);
				break;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		err_count++;
		$display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
	endtask

	// Result checker: each accepted word against the oldest expectation
	always @(posedge clk) begin : watch_results
		placement_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (placed_q.size() == 0) begin
				report_mismatch("result word with nothing pending", res_ch.point_index_out, 0);
			end else begin
				want = placed_q.pop_front();
				if (res_ch.point_index_out !== want.index)
					report_mismatch("point_index_out", res_ch.point_index_out, want.index);
				if (res_ch.level !== want.level)
					report_mismatch("level", res_ch.level, want.level);
				if (res_ch.node_x !== want.node_x)
					report_mismatch("node_x", res_ch.node_x, want.node_x);
				if (res_ch.node_y !== want.node_y)
					report_mismatch("node_y", res_ch.node_y, want.node_y);
				if (res_ch.node_z !== want.node_z)
					report_mismatch("node_z", res_ch.node_z, want.node_z);
				if (res_ch.cell_res !== want.cell_res)
					report_mismatch("cell_res", res_ch.cell_res, want.cell_res);
				if (res_ch.cell_recorded !== want.cell_recorded)
					report_mismatch("cell_recorded", res_ch.cell_recorded, want.cell_recorded);
			end
		end
	end

	// Receiver back-pressure in bursts of random length
	always @(posedge clk) begin : drive_ready
		if (ready_hold > 0) begin
			ready_hold--;
			res_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			ready_hold = $urandom_range(0, 4);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Send one point word; the prediction is made when it is taken
	task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
			logic signed [COORD_W-1:0] z, logic [INDEX_W-1:0] idx);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			pt_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		pt_ch.valid       <= 1'b1;
		pt_ch.coord_x     <= x;
		pt_ch.coord_y     <= y;
		pt_ch.coord_z     <= z;
		pt_ch.point_index <= idx;
		@(posedge clk);
		while (!pt_ch.ready) @(posedge clk);
		placed_q = {placed_q, predict_placement(x, y, z, idx)};
	endtask

	// Stop sending and let every pending result come back
	task automatic wait_idle();
		pt_ch.valid <= 1'b0;
		while (placed_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			CFG_DEEPEST_LEVEL: shadow.deepest_level = data[LVL_OUT_W-1:0];
			CFG_ORIGIN_X:      shadow.origin_x = data;
			CFG_ORIGIN_Y:      shadow.origin_y = data;
			CFG_ORIGIN_Z:      shadow.origin_z = data;
			CFG_CUBE_SHIFT:    shadow.cube_shift = data[SHIFT_W-1:0];
			default: ;
		endcase
	endtask

	// Write all registers; unused upper data bits carry noise. stray adds writes
	// to indexes past the register list, which must be ignored.
	task automatic apply_settings(logic [LVL_OUT_W-1:0] lvl, logic signed [COORD_W-1:0] ox,
			logic signed [COORD_W-1:0] oy, logic signed [COORD_W-1:0] oz,
			logic [SHIFT_W-1:0] sh, bit stray);
		write_reg(CFG_DEEPEST_LEVEL, ($urandom & ~32'(2 ** LVL_OUT_W - 1)) | 32'(lvl));
		if (stray) begin
			for (int i = CFG_FIRST_UNUSED; i < (1 << CFG_IDX_W); i++) begin
				write_reg(CFG_IDX_W'(i), $urandom);
			end
		end
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_ORIGIN_Z, oz);
		write_reg(CFG_CUBE_SHIFT, ($urandom & ~32'(2 ** SHIFT_W - 1)) | 32'(sh));
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic signed [COORD_W-1:0] rand_origin();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return COORD_W'(longint'($urandom_range(0, 1 << 21)) - (1 << 20));
		if (r == 6) return 32'sh8000_0000;
		if (r == 7) return 32'sh7FFF_FFFF;
		return $urandom;
	endfunction

	// Pick cluster centers inside the current cube
	task automatic reseed_clusters();
		longint mask;
		mask = (longint'(1) << shadow.cube_shift) - 1;
		for (int a = 0; a < 3; a++) begin
			for (int k = 0; k < CLUSTERS; k++) hot[a][k] = {$urandom, $urandom} & mask;
		end
	endtask

	// Mostly clustered points so that deep levels are reached; some spread,
	// some just outside the cube, some raw noise
	task automatic send_random_point();
		logic signed [COORD_W-1:0] c [3];
		logic signed [COORD_W-1:0] org [3];
		longint mask;
		longint off;
		int     mode;
		int     k;
		int     js;
		org[0] = shadow.origin_x;
		org[1] = shadow.origin_y;
		org[2] = shadow.origin_z;
		mask = (longint'(1) << shadow.cube_shift) - 1;
		mode = $urandom_range(0, 9);
		k = $urandom_range(0, CLUSTERS - 1);
		for (int a = 0; a < 3; a++) begin
			if (mode <= 5) begin
				js = $urandom_range(0, int'(shadow.cube_shift));
				off = (hot[a][k] + ({$urandom, $urandom} & ((longint'(1) << js) - 1))) & mask;
			end else if (mode <= 7) begin
				off = {$urandom, $urandom} & mask;
			end else if (mode == 8) begin
				off = $urandom_range(0, 1) ? mask + $urandom_range(1, 4)
					: -longint'($urandom_range(1, 4));
			end else begin
				off = 0;
			end
			c[a] = (mode == 9) ? $urandom : COORD_W'(longint'(org[a]) + off);
		end
		send_point(c[0], c[1], c[2], $urandom);
	endtask

	// Reset settings: repeated point climbs every level; field extremes clamp
	task automatic test_directed_corners();
		send_point(0, 0, 0, 32'h0000_0000);
		send_point(0, 0, 0, 32'hFFFF_FFFF);
		send_point(0, 0, 0, 32'h0000_0001);
		send_point(0, 0, 0, 32'h0000_0002);
		send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h8000_0000);
		send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'h7FFF_FFFF);
		send_point(65535, 0, -5, 32'h5555_5555);
		send_point(4096 * 3, 4096 * 5 + 17, 4096 * 7 + 4095, 32'hAAAA_AAAA);
		wait_idle();
	endtask

	// Register extremes: deepest level 0, tiny cube, full-range cube,
	// origin at the top, cells finer than one unit
	task automatic test_register_settings();
		apply_settings(0, 0, 0, 0, RST_CUBE_SHIFT, 1'b1);
		send_point(1000, 2000, 3000, 32'd10);
		send_point(1000, 2000, 3000, 32'd11);
		wait_idle();
		apply_settings(2, 100, 100, 100, 0, 1'b0);
		send_point(100, 100, 100, 32'd20);
		send_point(5000, -5000, 7, 32'd21);
		send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'd22);
		wait_idle();
		apply_settings(3, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31, 1'b0);
		send_point(0, 0, 0, 32'd30);
		send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'd31);
		send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'd32);
		wait_idle();
		apply_settings(3, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 7, 1'b0);
		send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'd40);
		send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'd41);
		wait_idle();
		apply_settings(3, -16, -16, -16, 3, 1'b0);
		send_point(-16, -16, -16, 32'd50);
		send_point(-15, -14, -9, 32'd51);
		send_point(-9, -9, -9, 32'd52);
		send_point(-10, -12, -13, 32'd53);
		wait_idle();
	endtask

	// Random phases, each with its own settings and clusters
	task automatic test_random_clusters();
		logic [LVL_OUT_W-1:0] lvl;
		logic [SHIFT_W-1:0]   sh;
		int                   r;
		for (int p = 0; p < RAND_PHASES; p++) begin
			idle_on = (p % 4 != 3);
			lvl = ($urandom_range(0, 9) < 7) ? LVL_OUT_W'(DEPTH_LIMIT) : $urandom_range(0, 2);
			r = $urandom_range(0, 9);
			if (r < 6) sh = $urandom_range(7, 16);
			else if (r == 6) sh = 31;
			else if (r == 7) sh = $urandom_range(0, 6);
			else sh = $urandom_range(17, 30);
			apply_settings(lvl, rand_origin(), rand_origin(), rand_origin(), sh, p == 0);
			reseed_clusters();
			repeat (PHASE_WORDS) send_random_point();
			wait_idle();
		end
	endtask

	// Closing stretch at full rate with no idling on either side
	task automatic test_final_stream();
		idle_on = 1'b0;
		apply_settings(3, rand_origin(), rand_origin(), rand_origin(), 9, 1'b0);
		reseed_clusters();
		repeat (TAIL_WORDS) send_random_point();
		wait_idle();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		pt_ch.valid = 1'b0;
		pt_ch.coord_x = '0;
		pt_ch.coord_y = '0;
		pt_ch.coord_z = '0;
		pt_ch.point_index = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		idle_on = 1'b1;
		shadow.deepest_level = RST_DEEPEST_LEVEL;
		shadow.origin_x = '0;
		shadow.origin_y = '0;
		shadow.origin_z = '0;
		shadow.cube_shift = RST_CUBE_SHIFT;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_corners();
		test_register_settings();
		test_random_clusters();
		test_final_stream();
		// let any stray result word show up
		repeat (40) @(posedge clk);
		if (err_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Hang guard, well above the slowest legal run
	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
